[design/tps_pkg.sv]
// Shared types and constants for the trapezoidal pulse shaper.
// Used by every module of the block; depends on nothing else.
package tps_pkg;

  localparam int DELAY_DEPTH_DEF = 4096;
  localparam int SAMPLE_BITS_DEF = 16;
  localparam int Q_DEPTH         = 2;

  localparam int XW   = 17;   // corrected sample
  localparam int DW   = 18;   // first difference
  localparam int EW   = 19;   // second difference
  localparam int A1W  = 32;
  localparam int A2W  = 64;
  localparam int OUTW = 48;
  localparam int PKW  = 47;
  localparam int CFGW = 17;

  typedef enum logic [2:0] {
    REG_PEAKING      = 3'd0,
    REG_GAP          = 3'd1,
    REG_DECAY_FACTOR = 3'd2,
    REG_DECAY_GAIN   = 3'd3,
    REG_BASELINE     = 3'd4,
    REG_INVERT       = 3'd5
  } tps_reg_t;

  typedef struct packed {
    logic [11:0] peaking;
    logic [11:0] gap;
    logic [15:0] decay_factor;
    logic [16:0] decay_gain;
    logic [15:0] baseline;
    logic        invert;
  } tps_cfg_t;

  typedef struct packed {
    logic [A2W-1:0] a2;
    logic           first;
    logic           last;
  } tps_item_t;

  typedef enum logic [2:0] {
    F_IDLE, F_SHORT, F_LONG, F_MUL, F_ACC
  } tps_fstate_t;

  typedef enum logic [1:0] {
    B_IDLE, B_DIV, B_DONE
  } tps_bstate_t;

endpackage

[design/trapezoidal_pulse_shaper.sv]
// Trapezoidal pulse shaper: top level with the configuration registers.
// Depends on tps_pkg, tps_front, tps_queue and tps_back.
//
// One result leaves for every sample taken. The front end steps a sample
// through F_SHORT, F_LONG, F_MUL and F_ACC (delay line reads and writes,
// accumulators, the two decay products); the back end divides the second
// accumulator by peaking * 256 one quotient bit per cycle, and that divider
// sets the sustained rate. A two-entry queue between the halves lets the
// front end take the next sample while a division runs. Configuration may be
// written only while no sample is in flight.
module trapezoidal_pulse_shaper import tps_pkg::*; #(
  parameter int DELAY_DEPTH = DELAY_DEPTH_DEF,
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            cfg_we,
  input  logic [2:0]      cfg_addr,
  input  logic [CFGW-1:0] cfg_wdata,
  input  logic            in_tvalid,
  output logic            in_tready,
  input  logic [15:0]     in_tdata,   // [15:0] sample
  input  logic            in_tuser,   // [0] first_sample
  input  logic            in_tlast,
  output logic            out_tvalid,
  input  logic            out_tready,
  output logic [95:0]     out_tdata,  // [47:0] shaped_value, [94:48] running_peak
  output logic            out_tlast
);

  tps_cfg_t  cfg_r;
  logic      q_full, q_empty, push, pop;
  tps_item_t push_item, pop_item;
  logic [OUTW-1:0] shaped;
  logic [PKW-1:0]  peak;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.peaking      <= 12'd16;
      cfg_r.gap          <= 12'd8;
      cfg_r.decay_factor <= 16'd1;
      cfg_r.decay_gain   <= 17'd0;
      cfg_r.baseline     <= 16'd0;
      cfg_r.invert       <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_addr)
        REG_PEAKING:      cfg_r.peaking      <= cfg_wdata[11:0];
        REG_GAP:          cfg_r.gap          <= cfg_wdata[11:0];
        REG_DECAY_FACTOR: cfg_r.decay_factor <= cfg_wdata[15:0];
        REG_DECAY_GAIN:   cfg_r.decay_gain   <= cfg_wdata[16:0];
        REG_BASELINE:     cfg_r.baseline     <= cfg_wdata[15:0];
        REG_INVERT:       cfg_r.invert       <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  tps_front #(
    .DELAY_DEPTH(DELAY_DEPTH),
    .SAMPLE_BITS(SAMPLE_BITS)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .in_sample (in_tdata),
    .in_first  (in_tuser),
    .in_last   (in_tlast),
    .q_full    (q_full),
    .push      (push),
    .push_item (push_item)
  );

  tps_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_item (push_item),
    .pop       (pop),
    .pop_item  (pop_item),
    .full      (q_full),
    .empty     (q_empty)
  );

  tps_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .peaking    (cfg_r.peaking),
    .q_empty    (q_empty),
    .pop        (pop),
    .item       (pop_item),
    .out_valid  (out_tvalid),
    .out_ready  (out_tready),
    .out_shaped (shaped),
    .out_peak   (peak),
    .out_last   (out_tlast)
  );

  assign out_tdata = {1'b0, peak, shaped};

endmodule

[design/tps_front.sv]
// Front end: baseline and polarity correction, the two delay lines and both
// accumulators. Depends on tps_pkg.
module tps_front import tps_pkg::*; #(
  parameter int DELAY_DEPTH = DELAY_DEPTH_DEF,
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  input  tps_cfg_t  cfg,
  input  logic      in_valid,
  output logic      in_ready,
  input  logic [15:0] in_sample,
  input  logic      in_first,
  input  logic      in_last,
  input  logic      q_full,
  output logic      push,
  output tps_item_t push_item
);

  localparam int AW = $clog2(DELAY_DEPTH);
  localparam int LW = $clog2(DELAY_DEPTH + 1);
  localparam logic [15:0] SMASK = (SAMPLE_BITS >= 16) ? 16'hFFFF
                                  : 16'((32'd1 << SAMPLE_BITS) - 32'd1);

  tps_fstate_t state_r, state_nxt;

  logic signed [XW-1:0] x_r;
  logic signed [DW-1:0] din_r;
  logic signed [EW-1:0] e_r;
  logic                 first_r, last_r;
  logic [AW-1:0]        sptr_r, lptr_r;
  logic                 swrap_r, lwrap_r;
  logic [LW-1:0]        shw_r, lhw_r;
  logic [A1W-1:0]       a1_r;
  logic [A2W-1:0]       a2_r;
  logic signed [35:0]   p1_r;
  logic signed [49:0]   p2_r;

  logic [XW-1:0] smem [DELAY_DEPTH];
  logic [DW-1:0] lmem [DELAY_DEPTH];
  logic [XW-1:0] srd_r;
  logic [DW-1:0] lrd_r;

  logic                 accept;
  logic signed [XW-1:0] xdiff, xval, kout;
  logic signed [DW-1:0] din, mout;
  logic signed [EW-1:0] e;
  logic [11:0]          peff;
  logic [12:0]          mraw;
  logic [LW-1:0]        klen, mlen, sinc, linc;
  logic [AW-1:0]        sraddr;
  logic [A2W-1:0]       a2_next;

  assign accept = (state_r == F_IDLE) && in_valid && !q_full;
  assign in_ready = (state_r == F_IDLE) && !q_full;

  assign xdiff = $signed({1'b0, in_sample & SMASK}) - $signed({1'b0, cfg.baseline});
  assign xval  = cfg.invert ? -xdiff : xdiff;

  // A zero peaking length behaves as one; both lengths are clamped to the depth.
  assign peff = (cfg.peaking == 12'd0) ? 12'd1 : cfg.peaking;
  assign mraw = {1'b0, peff} + {1'b0, cfg.gap};
  assign klen = (32'(peff) >= DELAY_DEPTH) ? LW'(DELAY_DEPTH) : LW'(peff);
  assign mlen = (32'(mraw) >= DELAY_DEPTH) ? LW'(DELAY_DEPTH) : LW'(mraw);
  assign sinc = LW'(sptr_r) + LW'(1);
  assign linc = LW'(lptr_r) + LW'(1);

  // Entries above the fill mark were never written since reset and read as zero.
  assign kout = (swrap_r && (LW'(sptr_r) < shw_r)) ? $signed(srd_r) : '0;
  assign mout = (lwrap_r && (LW'(lptr_r) < lhw_r)) ? $signed(lrd_r) : '0;
  assign din  = DW'(x_r) - DW'(kout);
  assign e    = EW'(din_r) - EW'(mout);

  assign sraddr  = in_first ? '0 : sptr_r;
  assign a2_next = a2_r + (64'(p1_r) << 16) + 64'(p2_r);

  always_comb begin
    state_nxt = state_r;
    push = 1'b0;
    case (state_r)
      F_IDLE:  if (accept) state_nxt = F_SHORT;
      F_SHORT: state_nxt = F_LONG;
      F_LONG:  state_nxt = F_MUL;
      F_MUL:   state_nxt = F_ACC;
      F_ACC: begin
        push = 1'b1;
        state_nxt = F_IDLE;
      end
      default: state_nxt = F_IDLE;
    endcase
  end

  assign push_item.a2    = a2_next;
  assign push_item.first = first_r;
  assign push_item.last  = last_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= F_IDLE;
      sptr_r  <= '0;
      lptr_r  <= '0;
      swrap_r <= 1'b0;
      lwrap_r <= 1'b0;
      shw_r   <= '0;
      lhw_r   <= '0;
      a1_r    <= '0;
      a2_r    <= '0;
    end else begin
      state_r <= state_nxt;
      case (state_r)
        F_IDLE: begin
          if (accept && in_first) begin
            sptr_r  <= '0;
            lptr_r  <= '0;
            swrap_r <= 1'b0;
            lwrap_r <= 1'b0;
            a1_r    <= '0;
            a2_r    <= '0;
          end
        end
        F_SHORT: begin
          if (LW'(sptr_r) == shw_r) shw_r <= shw_r + LW'(1);
          if (sinc >= klen) begin
            sptr_r  <= '0;
            swrap_r <= 1'b1;
          end else begin
            sptr_r <= AW'(sinc);
          end
        end
        F_LONG: begin
          if (LW'(lptr_r) == lhw_r) lhw_r <= lhw_r + LW'(1);
          if (linc >= mlen) begin
            lptr_r  <= '0;
            lwrap_r <= 1'b1;
          end else begin
            lptr_r <= AW'(linc);
          end
          a1_r <= a1_r + 32'(e);
        end
        F_ACC: a2_r <= a2_next;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      x_r     <= xval;
      first_r <= in_first;
      last_r  <= in_last;
    end
    if (state_r == F_SHORT) din_r <= din;
    if (state_r == F_LONG) e_r <= e;
    if (state_r == F_MUL) begin
      p1_r <= e_r * $signed({1'b0, cfg.decay_factor});
      p2_r <= $signed(a1_r) * $signed({1'b0, cfg.decay_gain});
    end
  end

  always_ff @(posedge clk) begin
    if (accept) srd_r <= smem[sraddr];
  end

  always_ff @(posedge clk) begin
    if (state_r == F_SHORT) smem[sptr_r] <= x_r;
  end

  always_ff @(posedge clk) begin
    if (state_r == F_SHORT) lrd_r <= lmem[lptr_r];
  end

  always_ff @(posedge clk) begin
    if (state_r == F_LONG) lmem[lptr_r] <= din_r;
  end

endmodule

[design/tps_queue.sv]
// Short queue of accumulated values between the front end and the divider.
// Depends on tps_pkg.
module tps_queue import tps_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      push,
  input  tps_item_t push_item,
  input  logic      pop,
  output tps_item_t pop_item,
  output logic      full,
  output logic      empty
);

  localparam int PW = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
  localparam int CW = $clog2(Q_DEPTH + 1);

  tps_item_t     mem [Q_DEPTH];
  logic [PW-1:0] wptr_r, rptr_r;
  logic [CW-1:0] count_r;

  assign full     = (count_r == CW'(Q_DEPTH));
  assign empty    = (count_r == '0);
  assign pop_item = mem[rptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r  <= '0;
      rptr_r  <= '0;
      count_r <= '0;
    end else begin
      if (push) wptr_r <= (wptr_r == PW'(Q_DEPTH - 1)) ? '0 : wptr_r + PW'(1);
      if (pop)  rptr_r <= (rptr_r == PW'(Q_DEPTH - 1)) ? '0 : rptr_r + PW'(1);
      if (push && !pop) count_r <= count_r + CW'(1);
      else if (pop && !push) count_r <= count_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem[wptr_r] <= push_item;
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n) push |-> !full)
    else $error("queue written while full");
  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n) pop |-> !empty)
    else $error("queue read while empty");
  a_count_up: assert property (@(posedge clk) disable iff (!rst_n)
    (push && !pop) |=> count_r == $past(count_r) + CW'(1))
    else $error("queue count did not follow a lone write");

endmodule

[design/tps_back.sv]
// Back end: bit-serial division of the second accumulator by peaking * 256,
// saturation, running peak and the output register. Depends on tps_pkg.
module tps_back import tps_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic [11:0]      peaking,
  input  logic             q_empty,
  output logic             pop,
  input  tps_item_t        item,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [OUTW-1:0]  out_shaped,
  output logic [PKW-1:0]   out_peak,
  output logic             out_last
);

  localparam logic [A2W-1:0] POS_MAX = 64'h0000_7FFF_FFFF_FFFF;
  localparam logic [A2W-1:0] NEG_MAX = 64'h0000_8000_0000_0000;

  tps_bstate_t state_r, state_nxt;

  logic [A2W-1:0]  dq_r;
  logic [19:0]     rem_r;
  logic [5:0]      cnt_r;
  logic            neg_r, first_r, last_r;
  logic [PKW-1:0]  peak_r;
  logic            out_valid_r;
  logic [OUTW-1:0] shaped_r;
  logic            last_out_r;

  logic [11:0]     peff;
  logic [19:0]     divisor;
  logic [20:0]     rem_sh;
  logic            ge;
  logic            load;
  logic [A2W-1:0]  qneg, qpos;
  logic [PKW-1:0]  peak_base, peak_new;
  logic [OUTW-1:0] shaped_new;

  assign peff    = (peaking == 12'd0) ? 12'd1 : peaking;
  assign divisor = {peff, 8'h00};
  assign rem_sh  = {rem_r, dq_r[A2W-1]};
  assign ge      = rem_sh >= {1'b0, divisor};
  assign load    = (state_r == B_DONE) && (!out_valid_r || out_ready);

  assign qneg       = (dq_r > NEG_MAX) ? NEG_MAX : dq_r;
  assign qpos       = (dq_r > POS_MAX) ? POS_MAX : dq_r;
  assign peak_base  = first_r ? '0 : peak_r;
  assign shaped_new = neg_r ? OUTW'(48'd0 - qneg[OUTW-1:0]) : qpos[OUTW-1:0];
  assign peak_new   = (!neg_r && (qpos[PKW-1:0] > peak_base)) ? qpos[PKW-1:0] : peak_base;

  always_comb begin
    state_nxt = state_r;
    pop = 1'b0;
    case (state_r)
      B_IDLE: begin
        if (!q_empty) begin
          pop = 1'b1;
          state_nxt = B_DIV;
        end
      end
      B_DIV:  if (cnt_r == 6'd63) state_nxt = B_DONE;
      B_DONE: if (load) state_nxt = B_IDLE;
      default: state_nxt = B_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= B_IDLE;
      out_valid_r <= 1'b0;
      peak_r      <= '0;
    end else begin
      state_r <= state_nxt;
      if (load) begin
        out_valid_r <= 1'b1;
        peak_r      <= peak_new;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Restoring division, one quotient bit per cycle; the dividend shifts out
  // of the top of dq_r while quotient bits shift in at the bottom.
  always_ff @(posedge clk) begin
    case (state_r)
      B_IDLE: begin
        if (pop) begin
          neg_r   <= item.a2[A2W-1];
          dq_r    <= item.a2[A2W-1] ? 64'd0 - item.a2 : item.a2;
          rem_r   <= '0;
          cnt_r   <= '0;
          first_r <= item.first;
          last_r  <= item.last;
        end
      end
      B_DIV: begin
        rem_r <= ge ? 20'(rem_sh - {1'b0, divisor}) : rem_sh[19:0];
        dq_r  <= {dq_r[A2W-2:0], ge};
        cnt_r <= cnt_r + 6'd1;
      end
      default: ;
    endcase
    if (load) begin
      shaped_r   <= shaped_new;
      last_out_r <= last_r;
    end
  end

  assign out_valid  = out_valid_r;
  assign out_shaped = shaped_r;
  assign out_peak   = peak_r;
  assign out_last   = last_out_r;

endmodule

[sim/tb_trapezoidal_pulse_shaper.sv]
// Self-checking testbench for the trapezoidal pulse shaper: drives sample streams,
// predicts the shaped value, running peak and pulse end, and checks each result.
// Depends on tps_pkg and the trapezoidal_pulse_shaper RTL.
module tb_trapezoidal_pulse_shaper import tps_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int DEPTH = 4096;
  localparam logic [63:0] SAT_MAX = 64'h7FFF_FFFF_FFFF;

  typedef struct packed {
    logic [15:0] sample;
    logic        first;
    logic        last;
  } sample_req_t;

  typedef struct packed {
    logic [47:0] shaped;
    logic [46:0] peak;
    logic        done;
  } shaped_res_t;

  logic            clk = 1'b0;
  logic            rst_n = 1'b0;
  logic            cfg_we = 1'b0;
  logic [2:0]      cfg_addr = '0;
  logic [CFGW-1:0] cfg_wdata = '0;
  logic            in_tvalid = 1'b0;
  logic            in_tready;
  logic [15:0]     in_tdata = '0;
  logic            in_tuser = 1'b0;
  logic            in_tlast = 1'b0;
  logic            out_tvalid;
  logic            out_tready = 1'b0;
  logic [95:0]     out_tdata;
  logic            out_tlast;

  trapezoidal_pulse_shaper i_dut (.*);

  always #1 clk = ~clk;

  // Shadow of the configuration and of the filter state.
  tps_cfg_t    shadow_cfg;
  logic signed [31:0] short_line [DEPTH];
  logic signed [31:0] long_line  [DEPTH];
  int unsigned short_ptr, long_ptr;
  bit          short_wrap, long_wrap;
  logic [31:0] acc1;
  logic [63:0] acc2;
  logic [63:0] peak_seen;

  sample_req_t pending_samples[$];
  shaped_res_t expected_results[$];
  int          send_idle_pct = 0, recv_idle_pct = 0;
  bit          hold_off = 1'b0;
  int          n_errors = 0, n_results = 0, n_pulses = 0;

  function automatic logic signed [31:0] pass_line(ref logic signed [31:0] line[DEPTH],
      ref int unsigned ptr, ref bit wrapped, input int unsigned len,
      input logic signed [31:0] value);
    logic signed [31:0] tapped;
    if (ptr >= DEPTH) ptr = 0;
    tapped = wrapped ? line[ptr] : 32'sd0;
    line[ptr] = value;
    ptr++;
    if (ptr >= len) begin
      ptr = 0;
      wrapped = 1'b1;
    end
    return tapped;
  endfunction

  function automatic shaped_res_t shape_sample(sample_req_t s);
    logic signed [31:0] x, k, d, m, e;
    int unsigned peff, klen, mlen;
    logic [63:0] term, mag, q;
    logic [63:0] a1s;
    shaped_res_t r;
    if (s.first) begin
      short_ptr = 0; long_ptr = 0; short_wrap = 0; long_wrap = 0;
      acc1 = '0; acc2 = '0; peak_seen = '0;
    end
    x = $signed({16'd0, s.sample}) - $signed({16'd0, shadow_cfg.baseline});
    if (shadow_cfg.invert) x = -x;
    peff = (shadow_cfg.peaking == 0) ? 1 : shadow_cfg.peaking;
    klen = (peff < DEPTH) ? peff : DEPTH;
    mlen = peff + shadow_cfg.gap;
    if (mlen > DEPTH) mlen = DEPTH;
    k = pass_line(short_line, short_ptr, short_wrap, klen, x);
    d = x - k;
    m = pass_line(long_line, long_ptr, long_wrap, mlen, d);
    e = d - m;
    acc1 = acc1 + e;
    a1s = {{32{acc1[31]}}, acc1};
    term = ({{32{e[31]}}, e} * {48'd0, shadow_cfg.decay_factor}) << 16;
    term = term + a1s * {47'd0, shadow_cfg.decay_gain};
    acc2 = acc2 + term;
    mag = acc2[63] ? -acc2 : acc2;
    q = mag / ({32'd0, peff} << 8);
    if (acc2[63]) begin
      if (q > SAT_MAX + 1) q = SAT_MAX + 1;
      r.shaped = 48'(-q);
    end else begin
      if (q > SAT_MAX) q = SAT_MAX;
      r.shaped = q[47:0];
      if (q > peak_seen) peak_seen = q;
    end
    r.peak = peak_seen[46:0];
    r.done = s.last;
    return r;
  endfunction

  // Driver: a request stays offered until taken, idling only between requests.
  always @(posedge clk) begin
    if (rst_n) begin
      if (!in_tvalid || in_tready) begin
        if (pending_samples.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
          sample_req_t s;
          s = pending_samples.pop_front();
          expected_results.push_back(shape_sample(s));
          in_tvalid <= 1'b1;
          in_tdata  <= s.sample;
          in_tuser  <= s.first;
          in_tlast  <= s.last;
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // Monitor: compares every result with the oldest prediction.
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_tvalid && out_tready) begin
        shaped_res_t want;
        if (expected_results.size() == 0) begin
          $error("result with no prediction waiting");
          n_errors++;
        end else begin
          want = expected_results.pop_front();
          n_results++;
          if (out_tlast) n_pulses++;
          if (out_tdata[47:0] !== want.shaped) begin
            $error("shaped_value: expected %h, got %h", want.shaped, out_tdata[47:0]);
            n_errors++;
          end
          if (out_tdata[94:48] !== want.peak) begin
            $error("running_peak: expected %h, got %h", want.peak, out_tdata[94:48]);
            n_errors++;
          end
          if (out_tlast !== want.done) begin
            $error("pulse_done: expected %b, got %b", want.done, out_tlast);
            n_errors++;
          end
        end
      end
      out_tready <= !hold_off && ($urandom_range(99) >= recv_idle_pct);
    end
  end

  task automatic write_reg(tps_reg_t idx, logic [CFGW-1:0] value);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_addr  <= idx;
    cfg_wdata <= value;
    case (idx)
      REG_PEAKING:      shadow_cfg.peaking      = value[11:0];
      REG_GAP:          shadow_cfg.gap          = value[11:0];
      REG_DECAY_FACTOR: shadow_cfg.decay_factor = value[15:0];
      REG_DECAY_GAIN:   shadow_cfg.decay_gain   = value[16:0];
      REG_BASELINE:     shadow_cfg.baseline     = value[15:0];
      REG_INVERT:       shadow_cfg.invert       = value[0];
      default: ;
    endcase
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic drain();
    wait (pending_samples.size() == 0 && expected_results.size() == 0);
    repeat (100) @(posedge clk);
  endtask

  // A pulse: rising edge, a flat top, a decaying tail, with some noise.
  task automatic queue_pulse(int len, int unsigned base, int unsigned amp);
    int unsigned v;
    for (int i = 0; i < len; i++) begin
      sample_req_t s;
      if (i < 3) v = base;
      else if (i < 6) v = base + amp;
      else v = base + (amp >> ((i - 5) / 2));
      v = v + $urandom_range(7);
      s.sample = (v > 65535) ? 16'hFFFF : v[15:0];
      s.first  = (i == 0);
      s.last   = (i == len - 1);
      pending_samples.push_back(s);
    end
  endtask

  task automatic random_phase(int n_items);
    int done_items = 0;
    while (done_items < n_items) begin
      if ($urandom_range(9) < 8) begin
        int len = $urandom_range(24, 4);
        queue_pulse(len, $urandom_range(4000), $urandom_range(65535));
        done_items += len;
      end else begin
        sample_req_t s;
        s = 18'($urandom);
        pending_samples.push_back(s);
        done_items++;
      end
    end
  endtask

  initial begin
    shadow_cfg = '{peaking: 16, gap: 8, decay_factor: 1, decay_gain: 0,
                   baseline: 0, invert: 0};
    for (int i = 0; i < DEPTH; i++) begin
      short_line[i] = 0;
      long_line[i] = 0;
    end
    short_ptr = 0; long_ptr = 0; short_wrap = 0; long_wrap = 0;
    acc1 = '0; acc2 = '0; peak_seen = '0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: extremes of the sample, flags, baseline and polarity.
    pending_samples.push_back('{16'hFFFF, 1'b1, 1'b0});
    pending_samples.push_back('{16'h0000, 1'b0, 1'b0});
    pending_samples.push_back('{16'hFFFF, 1'b0, 1'b0});
    pending_samples.push_back('{16'h5555, 1'b0, 1'b1});
    pending_samples.push_back('{16'hAAAA, 1'b0, 1'b0});  // continues without a first flag
    pending_samples.push_back('{16'h0000, 1'b1, 1'b1});
    drain();
    write_reg(REG_PEAKING, CFGW'(0));    // zero peaking acts as one
    write_reg(REG_GAP, CFGW'(0));
    write_reg(REG_DECAY_FACTOR, CFGW'(16'hFFFF));
    write_reg(REG_DECAY_GAIN, 17'h1FFFF);
    write_reg(REG_BASELINE, CFGW'(16'hFFFF));
    write_reg(REG_INVERT, CFGW'(1));
    for (int i = 0; i < 10; i++)
      pending_samples.push_back('{(i % 2) ? 16'h0000 : 16'hFFFF, i == 0, i == 9});
    drain();
    // Full-scale samples with a peaking length of one and the largest decay factor and gain.
    write_reg(REG_PEAKING, CFGW'(1));
    write_reg(REG_INVERT, CFGW'(0));
    write_reg(REG_BASELINE, CFGW'(0));
    for (int i = 0; i < 6; i++)
      pending_samples.push_back('{16'hFFFF, i == 0, i == 5});
    drain();
    // The long delay clamps to the store depth; short pulses never read either line back.
    write_reg(REG_PEAKING, CFGW'(12'hFFF));
    write_reg(REG_GAP, CFGW'(12'hFFF));
    write_reg(REG_DECAY_GAIN, 17'h10000);
    queue_pulse(8, 100, 30000);
    drain();

    // Random phases over several settings, with the idling mix changing.
    for (int ph = 0; ph < 6; ph++) begin
      write_reg(REG_PEAKING, CFGW'((ph == 5) ? 1 : $urandom_range(20, 1)));
      write_reg(REG_GAP, CFGW'((ph == 4) ? 0 : $urandom_range(10)));
      write_reg(REG_DECAY_FACTOR,
                CFGW'((ph == 3) ? 65535 : $urandom_range(65535, 1)));
      write_reg(REG_DECAY_GAIN, CFGW'($urandom_range(131071)));
      write_reg(REG_BASELINE, CFGW'($urandom_range(4000)));
      write_reg(REG_INVERT, CFGW'(ph[0]));
      if (ph < 2) begin
        send_idle_pct = 13; recv_idle_pct = 66;
      end else if (ph < 4) begin
        send_idle_pct = 66; recv_idle_pct = 13;
      end else begin
        send_idle_pct = 0; recv_idle_pct = 0;
      end
      if (ph == 4) begin
        // Receiver holds off while the sender keeps offering requests.
        hold_off = 1'b1;
        random_phase(150);
        repeat (600) @(posedge clk);
        hold_off = 1'b0;
      end else begin
        random_phase(150);
      end
      drain();
    end

    $display("Checked %0d results over %0d pulse ends, with several filter settings,",
             n_results, n_pulses);
    $display("saturation, polarity inversion and back-pressure on both sides.");
    if (n_errors == 0) begin
      $display("** trapezoidal_pulse_shaper: PASSED **");
    end else begin
      $display("** trapezoidal_pulse_shaper: FAILED **");
    end
    $finish;
  end

  // About 1000 requests, with stalls, fit well inside this.
  initial begin
    #2000000;
    $display("** trapezoidal_pulse_shaper: FAILED **");
    $finish;
  end
endmodule
